### src/vn_pkg.sv
// Shared constants, pipeline record types and helpers for the vector normaliser.
package vn_pkg;

  localparam int COMPONENT_BITS = 32;
  localparam int FRAC_BITS      = 16;
  localparam int W              = COMPONENT_BITS;
  localparam int SUM_W          = 2 * W;
  localparam int REM_W          = W + 1;
  localparam int QUO_W          = FRAC_BITS + 1;
  localparam int CMP_W          = ((W > QUO_W) ? W : QUO_W) + 1;
  // Register stages: square, sum, one per root bit, one per quotient bit.
  localparam int N_STG          = 2 + W + QUO_W;

  localparam logic [CMP_W-1:0] LIM_NEG = CMP_W'(1) << (W - 1);
  localparam logic [CMP_W-1:0] LIM_POS = LIM_NEG - CMP_W'(1);

  typedef struct packed {
    logic [W-1:0] raw_x;
    logic [W-1:0] raw_y;
    logic [W-1:0] raw_z;
    logic [W-1:0] mag_x;
    logic [W-1:0] mag_y;
    logic [W-1:0] mag_z;
  } side_t;

  typedef struct packed {
    logic [SUM_W-1:0] rad;
    logic [REM_W-1:0] rem;
    logic [W-1:0]     root;
    side_t            side;
  } sq_t;

  typedef struct packed {
    logic [W-1:0]     len;
    logic [W-1:0]     rem;
    logic [QUO_W-1:0] num;
    logic [QUO_W-1:0] quo;
    logic [W-1:0]     raw;
  } div_t;

  function automatic logic [W-1:0] abs_val(input logic [W-1:0] v);
    abs_val = v[W-1] ? (~v + W'(1)) : v;
  endfunction

  // Seed a divider lane: remainder starts at mag/2; the low bit of mag and FRAC_BITS zeros are left to shift in.
  function automatic div_t div_seed(input logic [W-1:0] raw, input logic [W-1:0] mag,
                                    input logic [W-1:0] len);
    div_t d;
    d.len = len;
    d.rem = mag >> 1;
    d.num = {mag[0], {FRAC_BITS{1'b0}}};
    d.quo = '0;
    d.raw = raw;
    div_seed = d;
  endfunction

  // Saturate the quotient and apply the component sign.
  function automatic logic [W-1:0] sign_sat(input logic [QUO_W-1:0] q, input logic neg);
    logic [CMP_W-1:0] qe;
    logic [CMP_W-1:0] qs;
    qe = CMP_W'(q);
    if (neg) begin
      qs = (qe > LIM_NEG) ? LIM_NEG : qe;
      sign_sat = W'(~qs + CMP_W'(1));
    end else begin
      qs = (qe > LIM_POS) ? LIM_POS : qe;
      sign_sat = W'(qs);
    end
  endfunction

endpackage

### src/vn_in_if.sv
// Input channel: one vector per transfer.
interface vn_in_if;
  import vn_pkg::*;
  logic         valid;
  logic         ready;
  logic [W-1:0] in_x;
  logic [W-1:0] in_y;
  logic [W-1:0] in_z;
  modport source (output valid, in_x, in_y, in_z, input ready);
  modport sink   (input valid, in_x, in_y, in_z, output ready);
endinterface

### src/vn_out_if.sv
// Output channel: normalised vector, magnitude and zero flag per transfer.
interface vn_out_if;
  import vn_pkg::*;
  logic         valid;
  logic         ready;
  logic [W-1:0] out_x;
  logic [W-1:0] out_y;
  logic [W-1:0] out_z;
  logic [W-1:0] length;
  logic         is_zero;
  modport source (output valid, out_x, out_y, out_z, length, is_zero, input ready);
  modport sink   (input valid, out_x, out_y, out_z, length, is_zero, output ready);
endinterface

### src/vn_sqrt_cell.sv
// One restoring square-root step: two radicand bits in, one root bit out.
module vn_sqrt_cell
  import vn_pkg::*;
(
  input  logic clk,
  input  logic en,
  input  sq_t  d,
  output sq_t  q
);

  logic [REM_W+1:0] acc;
  logic [REM_W+1:0] trial;
  logic             ge;
  sq_t              q_next;

  always_comb begin
    acc              = {d.rem, d.rad[SUM_W-1 -: 2]};
    trial            = (REM_W + 2)'({d.root, 2'b01});
    ge               = (acc >= trial);
    q_next.rad       = d.rad << 2;
    q_next.rem       = REM_W'(ge ? (acc - trial) : acc);
    q_next.root      = {d.root[W-2:0], ge};
    q_next.side      = d.side;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule

### src/vn_div_cell.sv
// One restoring division step: one quotient bit per cell.
module vn_div_cell
  import vn_pkg::*;
(
  input  logic clk,
  input  logic en,
  input  div_t d,
  output div_t q
);

  logic [W:0] acc;
  logic       ge;
  div_t       q_next;

  always_comb begin
    acc        = {d.rem, d.num[QUO_W-1]};
    ge         = (acc >= {1'b0, d.len});
    q_next     = d;
    q_next.rem = W'(ge ? (acc - {1'b0, d.len}) : acc);
    q_next.num = d.num << 1;
    q_next.quo = {d.quo[QUO_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule

### src/vector3_normalize_core.sv
// Top level of the 3D vector normaliser: squares, root chain, divider chains, output.
//
// Accepts one signed Q16.16 vector per clock and returns, for each, the
// components divided by the floored Euclidean magnitude (Q16.16, truncated
// towards zero), the magnitude itself and a zero flag; an all-zero vector
// comes back unchanged with the flag set. The datapath is a fully pipelined
// chain: one register stage of squares, one of their sum, one square-root
// cell per root bit (COMPONENT_BITS cells) and one divider cell per quotient
// bit (FRAC_BITS+1 cells, three lanes side by side), then the output
// register. Throughput is one item per cycle while the chain advances. The
// whole chain advances whenever the output register is empty or being
// taken; while a finished result waits unaccepted, the chain holds and
// input transfers stop until the result is taken.
module vector3_normalize_core
  import vn_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  vn_in_if.sink    in_ch,
  vn_out_if.source out_ch
);

  logic             en;
  logic [N_STG-1:0] vld;

  side_t            s1_side;
  logic [SUM_W-1:0] sq_x;
  logic [SUM_W-1:0] sq_y;
  logic [SUM_W-1:0] sq_z;

  sq_t              sq_seed;
  sq_t              sq_pipe [0:W];
  div_t             dv_x [0:QUO_W];
  div_t             dv_y [0:QUO_W];
  div_t             dv_z [0:QUO_W];

  logic             zero_c;

  // Advance everything when the output slot is free or being emptied.
  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[N_STG-2:0], in_ch.valid};
    end
  end

  // Square each magnitude; hold raw components for the zero bypass and signs.
  always_ff @(posedge clk) begin
    if (en) begin
      s1_side.raw_x <= in_ch.in_x;
      s1_side.raw_y <= in_ch.in_y;
      s1_side.raw_z <= in_ch.in_z;
      s1_side.mag_x <= abs_val(in_ch.in_x);
      s1_side.mag_y <= abs_val(in_ch.in_y);
      s1_side.mag_z <= abs_val(in_ch.in_z);
      sq_x          <= abs_val(in_ch.in_x) * abs_val(in_ch.in_x);
      sq_y          <= abs_val(in_ch.in_y) * abs_val(in_ch.in_y);
      sq_z          <= abs_val(in_ch.in_z) * abs_val(in_ch.in_z);
    end
  end

  // Sum of squares seeds the root chain; the sum cannot exceed 2*W bits.
  always_ff @(posedge clk) begin
    if (en) begin
      sq_seed.rad  <= sq_x + sq_y + sq_z;
      sq_seed.rem  <= '0;
      sq_seed.root <= '0;
      sq_seed.side <= s1_side;
    end
  end

  assign sq_pipe[0] = sq_seed;

  for (genvar k = 0; k < W; k++) begin : g_sqrt
    vn_sqrt_cell u_cell (
      .clk (clk),
      .en  (en),
      .d   (sq_pipe[k]),
      .q   (sq_pipe[k+1])
    );
  end

  // Seed three divider lanes from the finished root.
  assign dv_x[0] = div_seed(sq_pipe[W].side.raw_x, sq_pipe[W].side.mag_x, sq_pipe[W].root);
  assign dv_y[0] = div_seed(sq_pipe[W].side.raw_y, sq_pipe[W].side.mag_y, sq_pipe[W].root);
  assign dv_z[0] = div_seed(sq_pipe[W].side.raw_z, sq_pipe[W].side.mag_z, sq_pipe[W].root);

  for (genvar j = 0; j < QUO_W; j++) begin : g_div
    vn_div_cell u_dx (.clk(clk), .en(en), .d(dv_x[j]), .q(dv_x[j+1]));
    vn_div_cell u_dy (.clk(clk), .en(en), .d(dv_y[j]), .q(dv_y[j+1]));
    vn_div_cell u_dz (.clk(clk), .en(en), .d(dv_z[j]), .q(dv_z[j+1]));
  end

  // Zero magnitude only for the all-zero vector: pass raw components through.
  assign zero_c = (dv_x[QUO_W].len == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (en) begin
      out_ch.valid <= vld[N_STG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ch.length  <= dv_x[QUO_W].len;
      out_ch.is_zero <= zero_c;
      out_ch.out_x   <= zero_c ? dv_x[QUO_W].raw
                               : sign_sat(dv_x[QUO_W].quo, dv_x[QUO_W].raw[W-1]);
      out_ch.out_y   <= zero_c ? dv_y[QUO_W].raw
                               : sign_sat(dv_y[QUO_W].quo, dv_y[QUO_W].raw[W-1]);
      out_ch.out_z   <= zero_c ? dv_z[QUO_W].raw
                               : sign_sat(dv_z[QUO_W].quo, dv_z[QUO_W].raw[W-1]);
    end
  end

  // Zero flag and magnitude agree.
  a_zero_len: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.is_zero == (out_ch.length == '0)))
    else $error("zero flag disagrees with magnitude");

  // A normalised x component never exceeds one in magnitude.
  a_unit_x: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.is_zero) |->
      ($signed(out_ch.out_x) <= $signed(W'(1) << FRAC_BITS) &&
       $signed(out_ch.out_x) >= -$signed(W'(1) << FRAC_BITS)))
    else $error("normalised x out of unit range");

  // Nothing emerges from an empty pipe after reset.
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_ch.valid)
    else $error("output valid straight after reset");

endmodule

### tb/vector3_normalize_core_tb.sv
// Testbench for the vector normaliser: directed and random vectors, scoreboard check.
module vector3_normalize_core_tb;
  import vn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [W-1:0] ox;
    logic [W-1:0] oy;
    logic [W-1:0] oz;
    logic [W-1:0] len;
    logic         zero;
  } unit_vec_t;

  // Predicts the normalised vector for each accepted input and checks results in order.
  class norm_board;
    unit_vec_t pending[$];
    int        errors;

    function logic [W-1:0] floor_root(logic [SUM_W+1:0] s);
      logic [W-1:0]       r;
      logic [W-1:0]       t;
      logic [SUM_W+1:0]   sq;
      r = '0;
      for (int b = W - 1; b >= 0; b--) begin
        t  = r | (W'(1) << b);
        sq = (SUM_W+2)'(t) * (SUM_W+2)'(t);
        if (sq <= s) r = t;
      end
      return r;
    endfunction

    function void note_input(logic [W-1:0] x, logic [W-1:0] y, logic [W-1:0] z);
      logic [W-1:0]     raw[3];
      logic [W-1:0]     mg[3];
      logic [SUM_W+1:0] sum;
      logic [W+FRAC_BITS:0] q;
      logic [W+FRAC_BITS:0] lim;
      logic [W-1:0]     res[3];
      unit_vec_t        u;
      raw[0] = x; raw[1] = y; raw[2] = z;
      sum = '0;
      for (int i = 0; i < 3; i++) begin
        mg[i] = raw[i][W-1] ? -raw[i] : raw[i];
        sum += (SUM_W+2)'(mg[i]) * (SUM_W+2)'(mg[i]);
      end
      u.len = floor_root(sum);
      if (u.len == '0) begin
        res = raw;
        u.zero = 1'b1;
      end else begin
        u.zero = 1'b0;
        lim = (W+FRAC_BITS+1)'(1) << (W - 1);
        for (int i = 0; i < 3; i++) begin
          q = ((W+FRAC_BITS+1)'(mg[i]) << FRAC_BITS) / (W+FRAC_BITS+1)'(u.len);
          if (raw[i][W-1]) begin
            if (q > lim) q = lim;
            res[i] = W'(-q);
          end else begin
            if (q > lim - 1) q = lim - 1;
            res[i] = W'(q);
          end
        end
      end
      u.ox = res[0]; u.oy = res[1]; u.oz = res[2];
      pending.push_back(u);
    endfunction

    function void check_result(unit_vec_t got);
      unit_vec_t e;
      if (pending.size() == 0) begin
        $error("result with nothing pending");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.ox !== e.ox) begin $error("out_x exp %h got %h", e.ox, got.ox); errors++; end
      if (got.oy !== e.oy) begin $error("out_y exp %h got %h", e.oy, got.oy); errors++; end
      if (got.oz !== e.oz) begin $error("out_z exp %h got %h", e.oz, got.oz); errors++; end
      if (got.len !== e.len) begin
        $error("length exp %h got %h", e.len, got.len); errors++;
      end
      if (got.zero !== e.zero) begin
        $error("is_zero exp %b got %b", e.zero, got.zero); errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int   cycle;
  int   send_idle;   // percent of cycles the sender holds off
  int   recv_stall;  // percent of cycles the receiver stalls

  vn_in_if  in_ch();
  vn_out_if out_ch();
  norm_board board;

  vector3_normalize_core u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Cycle count and timeout guard.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > 400000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: stall at random, check every transfer on the output.
  always @(posedge clk) begin
    unit_vec_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.ox = out_ch.out_x; got.oy = out_ch.out_y; got.oz = out_ch.out_z;
      got.len = out_ch.length; got.zero = out_ch.is_zero;
      board.check_result(got);
    end
    out_ch.ready <= ($urandom_range(99) >= recv_stall);
  end

  // Offer one vector; hold it until the transfer happens.
  task automatic send_vec(logic [W-1:0] x, logic [W-1:0] y, logic [W-1:0] z);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_x <= x; in_ch.in_y <= y; in_ch.in_z <= z;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.note_input(x, y, z);
  endtask

  // Random component: full range a third of the time, else small, zero, most negative or mid-range.
  function automatic logic [W-1:0] rand_comp();
    case ($urandom_range(5))
      0: return W'($urandom_range(255)) - W'(128);
      1: return '0;
      2: return {1'b1, {(W-1){1'b0}}};
      3: return W'($urandom_range(65535)) << 4;
      default: return W'($urandom);
    endcase
  endfunction

  initial begin
    logic [W-1:0] mx;
    logic [W-1:0] mn;
    board = new();
    cycle = 0;
    send_idle = 0;
    recv_stall = 0;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.in_x = '0; in_ch.in_y = '0; in_ch.in_z = '0;
    out_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    mx = {1'b0, {(W-1){1'b1}}};
    mn = {1'b1, {(W-1){1'b0}}};
    // Directed: zero vector, unit axes, extremes, tiny magnitudes.
    send_vec('0, '0, '0);
    send_vec(W'(32'h0001_0000), '0, '0);
    send_vec('0, -W'(32'h0001_0000), '0);
    send_vec('0, '0, W'(1));
    send_vec(-W'(1), '0, '0);
    send_vec(mx, mx, mx);
    send_vec(mn, mn, mn);
    send_vec(mn, '0, '0);
    send_vec(mx, '0, '0);
    send_vec(mn, mx, '0);
    send_vec('1, '1, '1);
    send_vec(W'(1), W'(1), W'(1));
    send_vec(W'(3), -W'(4), '0);
    send_vec(mx, W'(1), mn);
    send_vec(W'(32'h5555_5555), W'(32'hAAAA_AAAA), W'(32'h0F0F_F0F0));
    // Random phases with varying idle and stall pressure.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 84; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 84; end
        default: begin send_idle = 24; recv_stall = 24; end
      endcase
      for (int n = 0; n < 100; n++) send_vec(rand_comp(), rand_comp(), rand_comp());
    end
    in_ch.valid <= 1'b0;
    recv_stall = 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (board.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule

### files.f
src/vn_pkg.sv
src/vn_in_if.sv
src/vn_out_if.sv
src/vn_sqrt_cell.sv
src/vn_div_cell.sv
src/vector3_normalize_core.sv
tb/vector3_normalize_core_tb.sv
